// File: rtl/mwmf_pkg.sv
// Package for the 3x3 hybrid median/mean filter: pixel and window types,
// fixed window geometry, divider constants and small compare helpers.
// Used by the front, queue and back modules; depends on nothing.
package mwmf_pkg;

   localparam int WINDOW_WIDTH  = 3;
   localparam int WINDOW_HEIGHT = 3;
   localparam int WIN_SIZE      = WINDOW_WIDTH * WINDOW_HEIGHT;
   localparam int NUM_COLORS    = 3;
   localparam int COMP_W        = 8;
   localparam int SUM_W         = 12;   // 8*255 + 2*255 fits in 12 bits

   // Color lanes inside a packed pixel.
   localparam int COLOR_BLUE  = 0;
   localparam int COLOR_GREEN = 1;
   localparam int COLOR_RED   = 2;

   // Division by ten: multiply by ceil(2^15/10) and keep bits [22:15].
   // The error stays below one unit of the result for sums under 16384.
   localparam int RECIP_SHIFT = 15;
   localparam int RECIP_W     = 12;
   localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(3277);
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam int MEDIAN_WEIGHT = 2;

   typedef logic [COMP_W-1:0]                 comp_type;
   typedef logic [NUM_COLORS-1:0][COMP_W-1:0] pixel_type;
   typedef pixel_type [WIN_SIZE-1:0]          window_type;
   typedef logic [$clog2(WIN_SIZE)-1:0]       win_idx_type;
   typedef logic [1:0]                        slot_type;
   typedef logic [SUM_W-1:0]                  sum_type;

   localparam win_idx_type CENTER_FULL = win_idx_type'(WIN_SIZE / 2);

   // One completed group handed from the front to the back.
   typedef struct packed {
      window_type  win;
      win_idx_type center;
   } job_type;

   function automatic comp_type max2(input comp_type a, input comp_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic comp_type min2(input comp_type a, input comp_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic comp_type max3(input comp_type a, input comp_type b,
                                     input comp_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic comp_type min3(input comp_type a, input comp_type b,
                                     input comp_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic comp_type med3(input comp_type a, input comp_type b,
                                     input comp_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Center column by age after a column group, given the updated slot.
   function automatic win_idx_type center_of_slot(input slot_type slot);
      win_idx_type idx;
      unique case (slot)
         2'd0:    idx = win_idx_type'(WINDOW_WIDTH + 1);
         2'd1:    idx = win_idx_type'(WINDOW_WIDTH + 2);
         default: idx = win_idx_type'(WINDOW_WIDTH);
      endcase
      return idx;
   endfunction

endpackage

// File: rtl/mwmf_if.sv
// Valid/ready channel interfaces of the 3x3 hybrid filter: the pixel
// request channel and the filtered result channel. No dependencies.
interface mwmf_req_if;
   logic       valid;
   logic       ready;
   logic       new_window;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, new_window, red_in, green_in, blue_in,
                   input ready);
   modport sink   (input valid, new_window, red_in, green_in, blue_in,
                   output ready);
endinterface

interface mwmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: rtl/median_weighted_mean_filter_3x3.sv
// 3x3 hybrid median/mean filter over RGB pixels.
// Requests (req_if) carry one pixel each. A group that starts with new_window
// set loads all nine window pixels in row-major order; a group that starts
// with it clear brings one three-pixel column, top to bottom, that replaces
// the oldest column. The first group after reset must be a full load.
// At the end of each group one response (rsp_if) carries, per color,
// (window sum - center pixel + 2 * median) / 10, truncated.
// Throughput: one request per cycle, sustained. The request channel is held
// off only while the job queue between the front and the back is full.
// Each group's result goes through the queue, then the row sort, median
// merge, weighted total, reciprocal multiply and result register stages.
// When the receiver stalls, the back pipeline freezes with the result held;
// the front keeps taking pixels until the queue fills.
// Reset (synchronous) empties the queue and pipeline and restarts the group
// and column counters; window contents are unknown until loaded.
module median_weighted_mean_filter_3x3 #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   mwmf_req_if.sink    req_if,
   mwmf_rsp_if.source  rsp_if
);
   import mwmf_pkg::*;

   logic    fr_push;
   job_type fr_job;
   logic    q_full;
   logic    q_valid;
   job_type q_job;
   logic    bk_pop;

   mwmf_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .push   (fr_push),
      .job    (fr_job)
   );

   mwmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fr_push),
      .push_job   (fr_job),
      .pop        (bk_pop),
      .head_valid (q_valid),
      .head_job   (q_job),
      .full       (q_full)
   );

   mwmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_job),
      .pop       (bk_pop),
      .rsp_if    (rsp_if)
   );

   // A completed group must never meet a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      fr_push |-> !q_full)
      else $error("job pushed into a full queue");

   // Requests are held off exactly while the queue is full.
   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_if.ready)
      else $error("request taken while the queue is full");

   // Reset leaves no response pending.
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule

// File: rtl/mwmf_front.sv
// Front end of the hybrid filter: takes pixel requests, keeps the 3x3 window
// and the column ring, and emits a job per completed group.
// Depends on mwmf_pkg and mwmf_req_if.
module mwmf_front (
   input  logic              clock,
   input  logic              reset,
   mwmf_req_if.sink          req_if,
   input  logic              q_full,
   output logic              push,
   output mwmf_pkg::job_type job
);
   import mwmf_pkg::*;

   window_type  win_ff, win_in;
   logic [3:0]  cnt_ff, cnt_in;
   slot_type    slot_ff, slot_in;
   logic        full_ff, full_in;
   logic        accept;
   logic        done;
   win_idx_type idx;
   pixel_type   pix;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      pix = '0;
      pix[COLOR_RED]   = req_if.red_in;
      pix[COLOR_GREEN] = req_if.green_in;
      pix[COLOR_BLUE]  = req_if.blue_in;

      // The kind of group is latched from the first request only.
      full_in = (cnt_ff == 4'd0) ? req_if.new_window : full_ff;

      if (full_in) begin
         idx  = win_idx_type'(cnt_ff);
         done = (cnt_ff == 4'(WIN_SIZE - 1));
      end else begin
         idx  = win_idx_type'(cnt_ff[1:0]) * win_idx_type'(WINDOW_WIDTH)
              + win_idx_type'(slot_ff);
         done = (cnt_ff == 4'(WINDOW_HEIGHT - 1));
      end

      win_in      = win_ff;
      win_in[idx] = pix;

      cnt_in  = done ? 4'd0 : cnt_ff + 4'd1;
      slot_in = slot_ff;
      if (done) begin
         if (full_in) begin
            slot_in = '0;
         end else begin
            slot_in = (slot_ff == slot_type'(WINDOW_WIDTH - 1)) ? '0 : slot_ff + 2'd1;
         end
      end

      job.win    = win_in;
      job.center = full_in ? CENTER_FULL : center_of_slot(slot_in);
      push       = accept && done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         slot_ff <= '0;
         full_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff  <= cnt_in;
         slot_ff <= slot_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// File: rtl/mwmf_queue.sv
// Short first-in first-out queue of jobs between the front and the back
// of the hybrid filter, with the head shown ahead. Depends on mwmf_pkg.
module mwmf_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mwmf_pkg::job_type push_job,
   input  logic              pop,
   output logic              head_valid,
   output mwmf_pkg::job_type head_job,
   output logic              full
);
   import mwmf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/mwmf_back.sv
// Back end of the hybrid filter: a five-stage pipeline that finds the median
// per color, forms sum - center + 2*median and divides it by ten.
// Depends on mwmf_pkg and mwmf_rsp_if.
module mwmf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  mwmf_pkg::job_type job,
   output logic              pop,
   mwmf_rsp_if.source        rsp_if
);
   import mwmf_pkg::*;

   logic en;

   // Stage 1: rows sorted, sum of the window less the center.
   logic     s1_valid_ff;
   comp_type s1_lo_ff  [NUM_COLORS][WINDOW_HEIGHT];
   comp_type s1_mid_ff [NUM_COLORS][WINDOW_HEIGHT];
   comp_type s1_hi_ff  [NUM_COLORS][WINDOW_HEIGHT];
   sum_type  s1_sum_ff [NUM_COLORS];
   // Stage 2: max of lows, median of mids, min of highs.
   logic     s2_valid_ff;
   comp_type s2_a_ff [NUM_COLORS];
   comp_type s2_b_ff [NUM_COLORS];
   comp_type s2_c_ff [NUM_COLORS];
   sum_type  s2_sum_ff [NUM_COLORS];
   // Stage 3: weighted total.
   logic     s3_valid_ff;
   sum_type  s3_total_ff [NUM_COLORS];
   // Stage 4: product with the reciprocal of ten.
   logic              s4_valid_ff;
   logic [PROD_W-1:0] s4_prod_ff [NUM_COLORS];
   // Stage 5: result register.
   logic     rsp_valid_ff;
   comp_type rsp_ff [NUM_COLORS];

   assign en  = !rsp_valid_ff || rsp_if.ready;
   assign pop = en;

   for (genvar c = 0; c < NUM_COLORS; c++) begin : g_color
      comp_type lo_in  [WINDOW_HEIGHT];
      comp_type mid_in [WINDOW_HEIGHT];
      comp_type hi_in  [WINDOW_HEIGHT];
      sum_type  sum_in;
      comp_type median;

      always_comb begin
         sum_in = '0;
         for (int i = 0; i < WIN_SIZE; i++) begin
            sum_in = sum_in + sum_type'(job.win[i][c]);
         end
         sum_in = sum_in - sum_type'(job.win[job.center][c]);
         for (int r = 0; r < WINDOW_HEIGHT; r++) begin
            lo_in[r]  = min3(job.win[3*r][c], job.win[3*r+1][c], job.win[3*r+2][c]);
            mid_in[r] = med3(job.win[3*r][c], job.win[3*r+1][c], job.win[3*r+2][c]);
            hi_in[r]  = max3(job.win[3*r][c], job.win[3*r+1][c], job.win[3*r+2][c]);
         end
         median = med3(s2_a_ff[c], s2_b_ff[c], s2_c_ff[c]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s1_lo_ff[c]    <= lo_in;
            s1_mid_ff[c]   <= mid_in;
            s1_hi_ff[c]    <= hi_in;
            s1_sum_ff[c]   <= sum_in;
            s2_a_ff[c]     <= max3(s1_lo_ff[c][0], s1_lo_ff[c][1], s1_lo_ff[c][2]);
            s2_b_ff[c]     <= med3(s1_mid_ff[c][0], s1_mid_ff[c][1], s1_mid_ff[c][2]);
            s2_c_ff[c]     <= min3(s1_hi_ff[c][0], s1_hi_ff[c][1], s1_hi_ff[c][2]);
            s2_sum_ff[c]   <= s1_sum_ff[c];
            s3_total_ff[c] <= s2_sum_ff[c]
                            + sum_type'(median) * sum_type'(MEDIAN_WEIGHT);
            s4_prod_ff[c]  <= PROD_W'(s3_total_ff[c]) * PROD_W'(RECIP_TEN);
            rsp_ff[c]      <= s4_prod_ff[c][RECIP_SHIFT +: COMP_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.red_out   = rsp_ff[COLOR_RED];
   assign rsp_if.green_out = rsp_ff[COLOR_GREEN];
   assign rsp_if.blue_out  = rsp_ff[COLOR_BLUE];

endmodule

// File: sim/median_weighted_mean_filter_3x3_test.sv
`timescale 1ns / 100ps
// Testbench for the 3x3 hybrid median/mean RGB filter: drives pixel requests,
// predicts every filtered result and checks the response stream field by field.
// Depends on mwmf_pkg, the mwmf_req_if/mwmf_rsp_if interfaces and the filter RTL.
module median_weighted_mean_filter_3x3_test;
   import mwmf_pkg::*;

   localparam int MEAN_DIVISOR   = 10;
   localparam int QUIET_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 30;

   typedef struct packed {
      comp_type red;
      comp_type green;
      comp_type blue;
   } rgb_type;

   logic clock;
   logic reset;

   mwmf_req_if req_chan ();
   mwmf_rsp_if rsp_chan ();

   median_weighted_mean_filter_3x3 uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   // Filter state as the block should hold it.
   comp_type    red_win   [WIN_SIZE];
   comp_type    green_win [WIN_SIZE];
   comp_type    blue_win  [WIN_SIZE];
   int unsigned ring_slot   = 0;
   int unsigned group_count = 0;
   bit          group_full  = 1'b0;

   rgb_type     filtered_rgb [$];
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_request = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic comp_type rand_comp();
      unique case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         2: return comp_type'($urandom_range(0, 3));
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic comp_type blend_channel(input comp_type w [WIN_SIZE],
                                              input int unsigned center);
      comp_type    sorted [WIN_SIZE];
      comp_type    v;
      int          j;
      int unsigned total;
      total = 0;
      sorted = w;
      for (int i = 0; i < WIN_SIZE; i++) total += w[i];
      for (int i = 1; i < WIN_SIZE; i++) begin
         v = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > v) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = v;
      end
      total = total - w[center] + MEDIAN_WEIGHT * sorted[WIN_SIZE / 2];
      return comp_type'(total / MEAN_DIVISOR);
   endfunction

   // Updates the window for one accepted pixel and queues the result of a
   // completed group. The flag only matters on the first pixel of a group.
   function automatic void track_pixel(input bit nw, input comp_type r,
                                       input comp_type g, input comp_type b);
      int unsigned idx;
      int unsigned center;
      bit          done;
      rgb_type     res;
      if (group_count == 0) group_full = nw;
      if (group_full) idx = group_count;
      else idx = group_count * WINDOW_WIDTH + ring_slot;
      red_win[idx]   = r;
      green_win[idx] = g;
      blue_win[idx]  = b;
      group_count++;
      done = 1'b0;
      center = 0;
      if (group_full) begin
         if (group_count == WIN_SIZE) begin
            done = 1'b1;
            ring_slot = 0;
            center = WIN_SIZE / 2;
         end
      end else if (group_count == WINDOW_HEIGHT) begin
         done = 1'b1;
         ring_slot = (ring_slot + 1) % WINDOW_WIDTH;
         center = WINDOW_WIDTH + (ring_slot + 1) % WINDOW_WIDTH;
      end
      if (done) begin
         group_count = 0;
         res.red   = blend_channel(red_win, center);
         res.green = blend_channel(green_win, center);
         res.blue  = blend_channel(blue_win, center);
         filtered_rgb = {filtered_rgb, res};
      end
   endfunction

   task automatic report_error(input string msg);
      if (error_count < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_pixel(input bit nw, input comp_type r, input comp_type g,
                             input comp_type b);
      int unsigned gap;
      gap = pick_gap(req_idle_on);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.new_window <= nw;
      req_chan.red_in     <= r;
      req_chan.green_in   <= g;
      req_chan.blue_in    <= b;
      do @(posedge clock); while (!req_chan.ready);
      track_pixel(nw, r, g, b);
   endtask

   // Full loads start about one group in eight; stray flags inside a group
   // are sprinkled in as noise since the block must ignore them.
   task automatic send_random_pixel();
      bit nw;
      if (group_count == 0) nw = ($urandom_range(0, 7) == 0);
      else nw = ($urandom_range(0, 3) == 0);
      send_pixel(nw, rand_comp(), rand_comp(), rand_comp());
   endtask

   task automatic stop_sender();
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (filtered_rgb.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      comp_type alt;
      // Alternating extremes with a ramp in blue.
      for (int i = 0; i < WIN_SIZE; i++) begin
         alt = (i % 2) ? 8'hff : 8'h00;
         send_pixel(i == 0, alt, ~alt, comp_type'(i * 28));
      end
      // Two columns with the full-load flag set inside the group.
      send_pixel(1'b0, 8'hff, 8'h00, 8'h80);
      send_pixel(1'b1, 8'h00, 8'hff, 8'h7f);
      send_pixel(1'b1, 8'h80, 8'h01, 8'hfe);
      send_pixel(1'b0, 8'h01, 8'hfe, 8'h00);
      send_pixel(1'b1, 8'hfe, 8'h80, 8'hff);
      send_pixel(1'b0, 8'h7f, 8'h7f, 8'h01);
      // Full load from the middle of the ring, flag held on every pixel.
      for (int i = 0; i < WIN_SIZE; i++) send_pixel(1'b1, 8'hff, 8'hff, 8'hff);
      for (int i = 0; i < WINDOW_HEIGHT; i++) send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
      stop_sender();
      wait_drained();
   endtask

   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (150) send_random_pixel();
      stop_sender();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_output_stall();
      req_idle_on = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (90) send_random_pixel();
      stop_sender();
      req_idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_drain_pause();
      repeat (31) send_random_pixel();
      stop_sender();
      wait_drained();
      repeat (29) send_random_pixel();
      stop_sender();
      wait_drained();
   endtask

   task automatic test_random_traffic();
      repeat (1000) send_random_pixel();
      stop_sender();
   endtask

   // Response side: random ready gaps, or one long hold when a test asks.
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = pick_gap(rsp_idle_on);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(0, 7)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (filtered_rgb.size() == 0) begin
            report_error("response with no request group pending");
         end else begin
            want = filtered_rgb.pop_front();
            if (rsp_chan.red_out !== want.red)
               report_error($sformatf("red_out %0d, want %0d", rsp_chan.red_out, want.red));
            if (rsp_chan.green_out !== want.green)
               report_error($sformatf("green_out %0d, want %0d",
                                      rsp_chan.green_out, want.green));
            if (rsp_chan.blue_out !== want.blue)
               report_error($sformatf("blue_out %0d, want %0d", rsp_chan.blue_out, want.blue));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("median_weighted_mean_filter_3x3_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.new_window <= 1'b0;
      req_chan.red_in     <= '0;
      req_chan.green_in   <= '0;
      req_chan.blue_in    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_rate();
      test_output_stall();
      test_drain_pause();
      test_random_traffic();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && filtered_rgb.size() == 0) begin
         $display("median_weighted_mean_filter_3x3_test: clean");
      end else begin
         $display("median_weighted_mean_filter_3x3_test: errors");
      end
      $finish;
   end

endmodule
